/* hw/rtl/krt_pkg.sv */
// Shared types, codes and constants of the keyed record table.
`default_nettype none

package krt_pkg;

    // Default number of records the table can hold.
    localparam int CAPACITY_DEF = 16;

    // Fixed field widths.
    localparam int KEY_W    = 32;
    localparam int YEAR_W   = 16;
    localparam int COURSE_W = 16;
    localparam int GRADE_W  = 8;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 3;
    localparam int ENTRY_W  = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUP     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_MISSING = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd4;

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [YEAR_W-1:0]   year;
        logic [COURSE_W-1:0] course_a;
        logic [GRADE_W-1:0]  grade_a;
        logic [COURSE_W-1:0] course_b;
        logic [GRADE_W-1:0]  grade_b;
        logic [COURSE_W-1:0] course_c;
        logic [GRADE_W-1:0]  grade_c;
    } t_record;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_LIST
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/keyed_record_table.sv */
// Top level of the keyed record table: sequencer, key compare and result registers.
`default_nettype none

// The table holds up to CAPACITY records in insertion order in one memory with a
// single read port, and every lookup (add, delete, read) and listing walks that
// memory one entry per cycle through one shared key comparator. An item is taken
// when start is high and busy is low. A delete that hits at position p then moves
// the later records down one per cycle. List gives one result per held key on
// consecutive cycles, with last_result on the final one. Full and empty cases
// answer in the cycle after the item is taken. Each result shows for exactly one
// cycle under o_valid and cannot be held off, so the receiver must take it then;
// busy drops in the cycle of the last result of an item.
module keyed_record_table #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [krt_pkg::OP_W-1:0]        i_operation,
    input  wire logic [krt_pkg::KEY_W-1:0]       i_student_key,
    input  wire logic [krt_pkg::YEAR_W-1:0]      i_year_in,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_a_in,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_a_in,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_b_in,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_b_in,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_c_in,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_c_in,
    output logic                                 o_valid,
    output logic [krt_pkg::STAT_W-1:0]           o_status,
    output logic [krt_pkg::KEY_W-1:0]            o_key_out,
    output logic [krt_pkg::YEAR_W-1:0]           o_year_out,
    output logic [krt_pkg::COURSE_W-1:0]         o_course_a_out,
    output logic [krt_pkg::GRADE_W-1:0]          o_grade_a_out,
    output logic [krt_pkg::COURSE_W-1:0]         o_course_b_out,
    output logic [krt_pkg::GRADE_W-1:0]          o_grade_b_out,
    output logic [krt_pkg::COURSE_W-1:0]         o_course_c_out,
    output logic [krt_pkg::GRADE_W-1:0]          o_grade_c_out,
    output logic [krt_pkg::ENTRY_W-1:0]          o_entry_count,
    output logic                                 o_last_result
);
    import krt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_state           r_state, n_state;
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    t_record          r_rec;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_chk_vld, n_chk_vld;
    logic [CW-1:0]    r_chk_idx, n_chk_idx;
    logic             r_valid, n_valid;
    logic [STAT_W-1:0] r_status, n_status;
    t_record          r_out, n_out;
    logic             r_last, n_last;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_record          wr_data;
    logic [AW-1:0]    rd_addr;
    t_record          rd_data;

    logic             accept;
    logic             issue;
    logic             hit;
    logic             last_chk;
    logic             is_full;
    logic             is_empty;
    logic [CW-1:0]    chk_prev;

    krt_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake and shared compare of the walked entry against the item's key.
    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign issue    = (r_idx < r_count);
    assign rd_addr  = issue ? r_idx[AW-1:0] : '0;
    assign hit      = r_chk_vld && (rd_data.key == r_key);
    assign last_chk = r_chk_vld && (r_chk_idx == r_count - CW'(1));
    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign chk_prev = r_chk_idx - CW'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_ADD:    n_state = is_full ? S_IDLE : S_SCAN;
                        OP_LIST:   n_state = is_empty ? S_IDLE : S_LIST;
                        default:   n_state = is_empty ? S_IDLE : S_SCAN;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (r_op == OP_DELETE && !last_chk) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (last_chk || is_empty) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (last_chk) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (last_chk) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and result values.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_chk_vld = 1'b0;
        n_chk_idx = r_idx;
        n_valid   = 1'b0;
        n_status  = STAT_OK;
        n_out     = '0;
        n_last    = 1'b1;
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = r_rec;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    case (i_operation)
                        OP_ADD: begin
                            if (is_full) begin
                                n_valid  = 1'b1;
                                n_status = STAT_FULL;
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx     = r_idx + CW'(issue);
                n_chk_vld = issue;
                if (hit) begin
                    case (r_op)
                        OP_ADD: begin
                            n_valid  = 1'b1;
                            n_status = STAT_DUP;
                        end
                        OP_READ: begin
                            n_valid  = 1'b1;
                            n_out    = rd_data;
                        end
                        default: begin
                            if (last_chk) begin
                                n_valid = 1'b1;
                                n_count = r_count - CW'(1);
                            end else begin
                                // Restart the walk just past the hit to move records down.
                                n_idx     = r_chk_idx + CW'(1);
                                n_chk_vld = 1'b0;
                            end
                        end
                    endcase
                end else if (last_chk || is_empty) begin
                    n_valid = 1'b1;
                    if (r_op == OP_ADD) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_status = STAT_MISSING;
                    end
                end
            end
            S_SHIFT: begin
                n_idx     = r_idx + CW'(issue);
                n_chk_vld = issue;
                if (r_chk_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = chk_prev[AW-1:0];
                    wr_data = rd_data;
                end
                if (last_chk) begin
                    n_valid = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            S_LIST: begin
                n_idx     = r_idx + CW'(issue);
                n_chk_vld = issue;
                if (r_chk_vld) begin
                    n_valid   = 1'b1;
                    n_out.key = rd_data.key;
                    n_last    = last_chk;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_chk_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_chk_vld <= n_chk_vld;
            r_chk_idx <= n_chk_idx;
            r_valid   <= n_valid;
        end
    end

    // Item capture and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op           <= i_operation;
            r_key          <= i_student_key;
            r_rec.key      <= i_student_key;
            r_rec.year     <= i_year_in;
            r_rec.course_a <= i_course_a_in;
            r_rec.grade_a  <= i_grade_a_in;
            r_rec.course_b <= i_course_b_in;
            r_rec.grade_b  <= i_grade_b_in;
            r_rec.course_c <= i_course_c_in;
            r_rec.grade_c  <= i_grade_c_in;
        end
        r_status <= n_status;
        r_out    <= n_out;
        r_last   <= n_last;
    end

    // Result ports.
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_key_out      = r_out.key;
    assign o_year_out     = r_out.year;
    assign o_course_a_out = r_out.course_a;
    assign o_grade_a_out  = r_out.grade_a;
    assign o_course_b_out = r_out.course_b;
    assign o_grade_b_out  = r_out.grade_b;
    assign o_course_c_out = r_out.course_c;
    assign o_grade_c_out  = r_out.grade_c;
    assign o_entry_count  = ENTRY_W'(r_count);
    assign o_last_result  = r_last;

    // The record count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("record count above capacity");

    // The final result of an item leaves the block free for the next one.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_result) |-> !busy)
        else $error("busy still high on final result");

    // An add into a full table answers full in the next cycle.
    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_ADD && is_full) |=> (o_valid && o_status == STAT_FULL))
        else $error("add into full table not refused");

    // The count only moves together with a result.
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> o_valid)
        else $error("record count changed without a result");

endmodule

`default_nettype wire

/* hw/rtl/krt_store.sv */
// Record memory: one write port and one registered read port.
`default_nettype none

module krt_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire krt_pkg::t_record  i_wr_data,
    input  wire logic [AW-1:0]     i_rd_addr,
    output krt_pkg::t_record       o_rd_data
);
    import krt_pkg::*;

    t_record r_mem [DEPTH];
    t_record r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data appears the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* tb/krt_checker.sv */
// Checker for the keyed record table: predicts every result word and compares it.
`timescale 1ns / 1ps

module krt_checker #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic                            i_busy,
    input  wire logic [krt_pkg::OP_W-1:0]        i_operation,
    input  wire logic [krt_pkg::KEY_W-1:0]       i_student_key,
    input  wire logic [krt_pkg::YEAR_W-1:0]      i_year_in,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_a_in,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_a_in,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_b_in,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_b_in,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_c_in,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_c_in,
    input  wire logic                            i_valid,
    input  wire logic [krt_pkg::STAT_W-1:0]      i_status,
    input  wire logic [krt_pkg::KEY_W-1:0]       i_key_out,
    input  wire logic [krt_pkg::YEAR_W-1:0]      i_year_out,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_a_out,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_a_out,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_b_out,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_b_out,
    input  wire logic [krt_pkg::COURSE_W-1:0]    i_course_c_out,
    input  wire logic [krt_pkg::GRADE_W-1:0]     i_grade_c_out,
    input  wire logic [krt_pkg::ENTRY_W-1:0]     i_entry_count,
    input  wire logic                            i_last_result,
    output int                                   o_failures,
    output int                                   o_pending,
    output int                                   o_held
);

    import krt_pkg::*;

    // One expected result word.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        t_record            rec;
        logic [ENTRY_W-1:0] count;
        logic               last;
    } t_reply;

    // Mirror of the table contents and the results still owed by the block.
    t_record table_rec [CAPACITY];
    int      held       = 0;
    int      fail_count = 0;
    t_reply  replies_due[$];

    // Position of the key in the table, or the record count when it is absent.
    function automatic int locate_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < held; i++) begin
            if (table_rec[i].key == key) begin
                return i;
            end
        end
        return held;
    endfunction

    // Queue one result word; the count always reflects the table after the word.
    task automatic owe_reply(logic [STAT_W-1:0] status, t_record rec, logic last);
        t_reply r;
        r.status = status;
        r.rec    = rec;
        r.count  = held[ENTRY_W-1:0];
        r.last   = last;
        replies_due.push_back(r);
    endtask

    // Apply one accepted command word to the mirror and queue its results.
    task automatic apply_command(logic [OP_W-1:0] op, t_record rec);
        int      pos;
        t_record listed;
        pos = locate_key(rec.key);
        case (op)
            OP_ADD: begin
                if (held >= CAPACITY) begin
                    owe_reply(STAT_FULL, '0, 1'b1);
                end else if (pos < held) begin
                    owe_reply(STAT_DUP, '0, 1'b1);
                end else begin
                    table_rec[held] = rec;
                    held++;
                    owe_reply(STAT_OK, '0, 1'b1);
                end
            end
            OP_DELETE: begin
                if (held == 0) begin
                    owe_reply(STAT_EMPTY, '0, 1'b1);
                end else if (pos >= held) begin
                    owe_reply(STAT_MISSING, '0, 1'b1);
                end else begin
                    // Close the gap so insertion order is kept.
                    for (int i = pos; i + 1 < held; i++) begin
                        table_rec[i] = table_rec[i + 1];
                    end
                    held--;
                    owe_reply(STAT_OK, '0, 1'b1);
                end
            end
            OP_READ: begin
                if (held == 0) begin
                    owe_reply(STAT_EMPTY, '0, 1'b1);
                end else if (pos >= held) begin
                    owe_reply(STAT_MISSING, '0, 1'b1);
                end else begin
                    owe_reply(STAT_OK, table_rec[pos], 1'b1);
                end
            end
            default: begin
                // A listing gives one word per held key, or a single empty word.
                if (held == 0) begin
                    owe_reply(STAT_EMPTY, '0, 1'b1);
                end else begin
                    for (int k = 0; k < held; k++) begin
                        listed     = '0;
                        listed.key = table_rec[k].key;
                        owe_reply(STAT_OK, listed, k == held - 1);
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Results are checked before new commands are applied; a result word and
    // the next command may share a clock edge.
    always @(posedge i_clk) begin
        t_reply  want;
        t_record cmd;
        if (!i_rst_n) begin
            held = 0;
            replies_due.delete();
        end else begin
            if (i_valid !== 1'b0) begin
                if (replies_due.size() == 0) begin
                    $error("result word with no result expected");
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("key_out", want.rec.key, i_key_out);
                    check_field("year_out", 32'(want.rec.year), 32'(i_year_out));
                    check_field("course_a_out", 32'(want.rec.course_a),
                                32'(i_course_a_out));
                    check_field("grade_a_out", 32'(want.rec.grade_a),
                                32'(i_grade_a_out));
                    check_field("course_b_out", 32'(want.rec.course_b),
                                32'(i_course_b_out));
                    check_field("grade_b_out", 32'(want.rec.grade_b),
                                32'(i_grade_b_out));
                    check_field("course_c_out", 32'(want.rec.course_c),
                                32'(i_course_c_out));
                    check_field("grade_c_out", 32'(want.rec.grade_c),
                                32'(i_grade_c_out));
                    check_field("entry_count", 32'(want.count), 32'(i_entry_count));
                    check_field("last_result", 32'(want.last), 32'(i_last_result));
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                cmd.key      = i_student_key;
                cmd.year     = i_year_in;
                cmd.course_a = i_course_a_in;
                cmd.grade_a  = i_grade_a_in;
                cmd.course_b = i_course_b_in;
                cmd.grade_b  = i_grade_b_in;
                cmd.course_c = i_course_c_in;
                cmd.grade_c  = i_grade_c_in;
                apply_command(i_operation, cmd);
            end
        end
        o_failures <= fail_count;
        o_pending  <= replies_due.size();
        o_held     <= held;
    end

endmodule

/* tb/tb.sv */
// Testbench top for the keyed record table: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    import krt_pkg::*;

    localparam int CAP           = CAPACITY_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 2 * CAP + 16;
    localparam int POOL_SIZE     = 24;
    localparam int RANDOM_WORDS  = 89;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_operation;
    logic [KEY_W-1:0]    i_student_key;
    logic [YEAR_W-1:0]   i_year_in;
    logic [COURSE_W-1:0] i_course_a_in;
    logic [GRADE_W-1:0]  i_grade_a_in;
    logic [COURSE_W-1:0] i_course_b_in;
    logic [GRADE_W-1:0]  i_grade_b_in;
    logic [COURSE_W-1:0] i_course_c_in;
    logic [GRADE_W-1:0]  i_grade_c_in;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic [KEY_W-1:0]    o_key_out;
    logic [YEAR_W-1:0]   o_year_out;
    logic [COURSE_W-1:0] o_course_a_out;
    logic [GRADE_W-1:0]  o_grade_a_out;
    logic [COURSE_W-1:0] o_course_b_out;
    logic [GRADE_W-1:0]  o_grade_b_out;
    logic [COURSE_W-1:0] o_course_c_out;
    logic [GRADE_W-1:0]  o_grade_c_out;
    logic [ENTRY_W-1:0]  o_entry_count;
    logic                o_last_result;

    int failures;
    int pending;
    int held_now;
    int cycle_count = 0;
    bit no_idle     = 1'b0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    keyed_record_table #(
        .CAPACITY(CAP)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_student_key  (i_student_key),
        .i_year_in      (i_year_in),
        .i_course_a_in  (i_course_a_in),
        .i_grade_a_in   (i_grade_a_in),
        .i_course_b_in  (i_course_b_in),
        .i_grade_b_in   (i_grade_b_in),
        .i_course_c_in  (i_course_c_in),
        .i_grade_c_in   (i_grade_c_in),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_key_out      (o_key_out),
        .o_year_out     (o_year_out),
        .o_course_a_out (o_course_a_out),
        .o_grade_a_out  (o_grade_a_out),
        .o_course_b_out (o_course_b_out),
        .o_grade_b_out  (o_grade_b_out),
        .o_course_c_out (o_course_c_out),
        .o_grade_c_out  (o_grade_c_out),
        .o_entry_count  (o_entry_count),
        .o_last_result  (o_last_result)
    );

    krt_checker #(
        .CAPACITY(CAP)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_operation    (i_operation),
        .i_student_key  (i_student_key),
        .i_year_in      (i_year_in),
        .i_course_a_in  (i_course_a_in),
        .i_grade_a_in   (i_grade_a_in),
        .i_course_b_in  (i_course_b_in),
        .i_grade_b_in   (i_grade_b_in),
        .i_course_c_in  (i_course_c_in),
        .i_grade_c_in   (i_grade_c_in),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_key_out      (o_key_out),
        .i_year_out     (o_year_out),
        .i_course_a_out (o_course_a_out),
        .i_grade_a_out  (o_grade_a_out),
        .i_course_b_out (o_course_b_out),
        .i_grade_b_out  (o_grade_b_out),
        .i_course_c_out (o_course_c_out),
        .i_grade_c_out  (o_grade_c_out),
        .i_entry_count  (o_entry_count),
        .i_last_result  (o_last_result),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_held         (held_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keyed_record_table: mismatch");
            $finish;
        end
    end

    function automatic t_record random_record(logic [KEY_W-1:0] key);
        t_record r;
        r.key      = key;
        r.year     = YEAR_W'($urandom);
        r.course_a = COURSE_W'($urandom);
        r.grade_a  = GRADE_W'($urandom);
        r.course_b = COURSE_W'($urandom);
        r.grade_b  = GRADE_W'($urandom);
        r.course_c = COURSE_W'($urandom);
        r.grade_c  = GRADE_W'($urandom);
        return r;
    endfunction

    // Present one command word after a random gap and hold it until it is taken.
    task automatic send_command(logic [OP_W-1:0] op, t_record rec);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_operation   <= op;
        i_student_key <= rec.key;
        i_year_in     <= rec.year;
        i_course_a_in <= rec.course_a;
        i_grade_a_in  <= rec.grade_a;
        i_course_b_in <= rec.course_b;
        i_grade_b_in  <= rec.grade_b;
        i_course_c_in <= rec.course_c;
        i_grade_c_in  <= rec.grade_c;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Hold off new commands until every owed result word has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        bit               grow;
        int               pick;

        start         <= 1'b0;
        i_rst_n       <= 1'b0;
        i_operation   <= OP_ADD;
        i_student_key <= '0;
        i_year_in     <= '0;
        i_course_a_in <= '0;
        i_grade_a_in  <= '0;
        i_course_b_in <= '0;
        i_grade_b_in  <= '0;
        i_course_c_in <= '0;
        i_grade_c_in  <= '0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty table, extreme keys and fields, duplicates,
        // misses, and deletes at the front, middle and end of the table.
        send_command(OP_LIST,   random_record('0));
        send_command(OP_READ,   random_record('0));
        send_command(OP_DELETE, random_record('1));
        send_command(OP_ADD,    '0);
        send_command(OP_ADD,    '1);
        send_command(OP_ADD,    random_record('0));
        send_command(OP_READ,   random_record('0));
        send_command(OP_READ,   random_record('1));
        send_command(OP_READ,   random_record(32'h1234_5678));
        send_command(OP_DELETE, random_record(32'h1234_5678));
        send_command(OP_ADD,    random_record(key_pool[0]));
        send_command(OP_ADD,    random_record(key_pool[1]));
        send_command(OP_LIST,   random_record('1));
        send_command(OP_DELETE, random_record('1));
        send_command(OP_READ,   random_record(key_pool[1]));
        send_command(OP_DELETE, random_record(key_pool[1]));
        send_command(OP_DELETE, random_record('0));
        send_command(OP_LIST,   random_record('0));
        send_command(OP_DELETE, random_record(key_pool[0]));
        send_command(OP_LIST,   random_record('0));
        send_command(OP_ADD,    random_record(key_pool[2]));
        wait_drained();

        // Random part: alternate between filling the table up to full and
        // draining it, with keys mostly from a small pool so that hits,
        // duplicates and misses all occur.
        grow = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 20 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (held_now >= CAP && $urandom_range(0, 3) == 0) begin
                grow = 1'b0;
            end else if (held_now <= 1) begin
                grow = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (grow) begin
                op = (pick < 65) ? OP_ADD : (pick < 80) ? OP_READ :
                     (pick < 90) ? OP_DELETE : OP_LIST;
            end else begin
                op = (pick < 15) ? OP_ADD : (pick < 30) ? OP_READ :
                     (pick < 85) ? OP_DELETE : OP_LIST;
            end
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) :
                  key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 29) == 0) begin
                wait_drained();
            end
            send_command(op, random_record(key));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("keyed_record_table: match");
        end else begin
            $display("keyed_record_table: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/krt_pkg.sv
hw/rtl/krt_store.sv
hw/rtl/keyed_record_table.sv
tb/krt_checker.sv
tb/tb.sv
